@@ hw/rtl/avctp_pkg.sv @@
// ----------------------------------------------------------------------------
// AVCTP transmit fragmenter package
// Shared types, header codes and constants for the fragmenter modules.
// ----------------------------------------------------------------------------
package avctp_pkg;

  // Floor and reset value of the peer MTU register.
  localparam logic [15:0] MTU_FLOOR = 16'd48;
  localparam logic [15:0] MTU_RESET = 16'd672;

  // Largest packet count that fits the count byte of a start header.
  localparam logic [15:0] CNT_MAX = 16'h00FF;

  // The count divider resolves one quotient bit per cycle.
  localparam int unsigned DIV_W     = 16;
  localparam int unsigned DIV_CNT_W = $clog2(DIV_W + 1);

  // Packet type field of the first header byte.
  typedef enum logic [1:0] {
    TYPE_SINGLE   = 2'd0,
    TYPE_START    = 2'd1,
    TYPE_CONTINUE = 2'd2,
    TYPE_END      = 2'd3
  } hdr_type_t;

  // Source of the byte that is loaded into the output register.
  typedef enum logic [2:0] {
    SEL_HDR0 = 3'd0,
    SEL_CNT  = 3'd1,
    SEL_PIDH = 3'd2,
    SEL_PIDL = 3'd3,
    SEL_PAY  = 3'd4
  } out_sel_t;

  typedef struct packed {
    logic [7:0]  payload_byte;
    logic [15:0] msg_length;
    logic [3:0]  msg_label;
    logic        cmd_resp;
    logic [15:0] profile_id;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       end_of_packet;
    logic       end_of_message;
    logic       count_overflow;
  } out_item_t;

  // Controller to datapath.
  typedef struct packed {
    logic     accept;
    logic     load_out;
    out_sel_t sel;
  } ctl_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic      need_hdr;
    hdr_type_t hdr_type;
    logic      div_busy;
  } dp_sts_t;

endpackage

@@ hw/rtl/avctp_div.sv @@
// ----------------------------------------------------------------------------
// AVCTP packet count divider
// Restoring unsigned divider that produces one quotient bit per cycle.
// ----------------------------------------------------------------------------
module avctp_div
  import avctp_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [DIV_W-1:0] dividend,
  input  logic [DIV_W-1:0] divisor,
  output logic             busy,
  output logic [DIV_W-1:0] quotient,
  output logic [DIV_W-1:0] remainder
);

  logic [DIV_CNT_W-1:0] count;
  logic [DIV_W-1:0]     quo;
  logic [DIV_W-1:0]     rem;
  logic [DIV_W-1:0]     dsr;
  logic [DIV_W:0]       shifted;
  logic [DIV_W:0]       diff;
  logic                 fits;

  assign shifted = {rem, quo[DIV_W-1]};
  assign fits    = shifted >= {1'b0, dsr};
  assign diff    = shifted - {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      count <= '0;
    end else if (start) begin
      busy  <= 1'b1;
      count <= DIV_CNT_W'(DIV_W);
    end else if (busy) begin
      count <= count - DIV_CNT_W'(1);
      if (count == DIV_CNT_W'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
      dsr <= divisor;
    end else if (busy) begin
      quo <= {quo[DIV_W-2:0], fits};
      rem <= fits ? diff[DIV_W-1:0] : shifted[DIV_W-1:0];
    end
  end

  assign quotient  = quo;
  assign remainder = rem;

endmodule

@@ hw/rtl/avctp_dpath.sv @@
// ----------------------------------------------------------------------------
// AVCTP fragmenter datapath
// Holds the message counters, header fields, MTU register and output byte.
// ----------------------------------------------------------------------------
module avctp_dpath
  import avctp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  input  logic [15:0] cfg_data,
  input  in_item_t    in_data,
  input  ctl_cmd_t    cmd,
  output dp_sts_t     sts,
  output out_item_t   out_data
);

  logic [15:0] mtu;
  logic [15:0] message_bytes_left;
  logic [15:0] packet_bytes_left;
  logic [3:0]  held_label;
  logic        held_cmd_resp;
  logic [15:0] held_pid;
  logic [7:0]  held_byte;
  hdr_type_t   hdr_type;

  logic [15:0] len;
  logic        frag;
  logic        div_busy;
  logic [15:0] quo;
  logic [15:0] rem;
  logic [15:0] cnt;
  logic        new_msg;
  logic        div_start;
  logic        load_pay;

  assign new_msg = message_bytes_left == '0;
  assign len     = (in_data.msg_length == '0) ? 16'd1 : in_data.msg_length;
  assign frag    = len > (mtu - 16'd3);
  assign div_start = cmd.accept && new_msg && frag;
  assign load_pay  = cmd.load_out && (cmd.sel == SEL_PAY);

  // Packet count is the start packet plus the rounded-up number of follow-ups.
  assign cnt = quo + 16'd1 + {15'd0, rem != '0};

  avctp_div u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (len - (mtu - 16'd4)),
    .divisor   (mtu - 16'd1),
    .busy      (div_busy),
    .quotient  (quo),
    .remainder (rem)
  );

  // The floor is applied as the register is written.
  always_ff @(posedge clk) begin
    if (rst) begin
      mtu <= MTU_RESET;
    end else if (cfg_valid) begin
      mtu <= (cfg_data < MTU_FLOOR) ? MTU_FLOOR : cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      message_bytes_left <= '0;
      packet_bytes_left  <= '0;
      held_label         <= '0;
      held_cmd_resp      <= 1'b0;
      hdr_type           <= TYPE_SINGLE;
    end else if (load_pay) begin
      message_bytes_left <= message_bytes_left - 16'd1;
      packet_bytes_left  <= (message_bytes_left == 16'd1) ? 16'd0
                                                          : packet_bytes_left - 16'd1;
    end else if (cmd.accept && sts.need_hdr) begin
      if (new_msg) begin
        message_bytes_left <= len;
        held_label         <= in_data.msg_label;
        held_cmd_resp      <= in_data.cmd_resp;
        if (frag) begin
          packet_bytes_left <= mtu - 16'd4;
          hdr_type          <= TYPE_START;
        end else begin
          packet_bytes_left <= len;
          hdr_type          <= TYPE_SINGLE;
        end
      end else if (message_bytes_left > (mtu - 16'd1)) begin
        packet_bytes_left <= mtu - 16'd1;
        hdr_type          <= TYPE_CONTINUE;
      end else begin
        packet_bytes_left <= message_bytes_left;
        hdr_type          <= TYPE_END;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      held_byte <= in_data.payload_byte;
      if (new_msg) begin
        held_pid <= in_data.profile_id;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      case (cmd.sel)
        SEL_HDR0: begin
          out_data <= '{out_byte: {held_label, hdr_type, held_cmd_resp, 1'b0},
                        end_of_packet: 1'b0, end_of_message: 1'b0,
                        count_overflow: 1'b0};
        end
        SEL_CNT: begin
          out_data <= '{out_byte: cnt[7:0], end_of_packet: 1'b0,
                        end_of_message: 1'b0, count_overflow: cnt > CNT_MAX};
        end
        SEL_PIDH: begin
          out_data <= '{out_byte: held_pid[15:8], end_of_packet: 1'b0,
                        end_of_message: 1'b0, count_overflow: 1'b0};
        end
        SEL_PIDL: begin
          out_data <= '{out_byte: held_pid[7:0], end_of_packet: 1'b0,
                        end_of_message: 1'b0, count_overflow: 1'b0};
        end
        SEL_PAY: begin
          out_data <= '{out_byte: cmd.accept ? in_data.payload_byte : held_byte,
                        end_of_packet: packet_bytes_left == 16'd1,
                        end_of_message: message_bytes_left == 16'd1,
                        count_overflow: 1'b0};
        end
        default: begin
          out_data <= '{out_byte: held_byte, end_of_packet: 1'b0,
                        end_of_message: 1'b0, count_overflow: 1'b0};
        end
      endcase
    end
  end

  assign sts = '{need_hdr: new_msg || (packet_bytes_left == '0),
                 hdr_type: hdr_type,
                 div_busy: div_busy};

endmodule

@@ hw/rtl/avctp_ctrl.sv @@
// ----------------------------------------------------------------------------
// AVCTP fragmenter controller
// Sequences header and payload bytes into the output register.
// ----------------------------------------------------------------------------
module avctp_seq
  import avctp_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_stall,
  output logic     out_valid,
  input  logic     out_stall,
  input  dp_sts_t  sts,
  output ctl_cmd_t cmd
);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_HDR0 = 6'b000010,
    S_CNT  = 6'b000100,
    S_PIDH = 6'b001000,
    S_PIDL = 6'b010000,
    S_PAY  = 6'b100000
  } state_t;

  state_t state;
  state_t state_next;
  logic   slot_free;

  // The output register can take a byte when empty or when its byte leaves now.
  assign slot_free = !out_valid || !out_stall;
  assign in_stall  = !((state == S_IDLE) && slot_free);

  always_comb begin
    state_next   = state;
    cmd.accept   = 1'b0;
    cmd.load_out = 1'b0;
    cmd.sel      = SEL_PAY;
    case (state)
      S_IDLE: begin
        if (in_valid && slot_free) begin
          cmd.accept = 1'b1;
          if (sts.need_hdr) begin
            state_next = S_HDR0;
          end else begin
            cmd.load_out = 1'b1;
          end
        end
      end
      S_HDR0: begin
        cmd.sel = SEL_HDR0;
        if (slot_free) begin
          cmd.load_out = 1'b1;
          case (sts.hdr_type)
            TYPE_SINGLE: state_next = S_PIDH;
            TYPE_START:  state_next = S_CNT;
            default:     state_next = S_PAY;
          endcase
        end
      end
      S_CNT: begin
        cmd.sel = SEL_CNT;
        if (slot_free && !sts.div_busy) begin
          cmd.load_out = 1'b1;
          state_next   = S_PIDH;
        end
      end
      S_PIDH: begin
        cmd.sel = SEL_PIDH;
        if (slot_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_PIDL;
        end
      end
      S_PIDL: begin
        cmd.sel = SEL_PIDL;
        if (slot_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_PAY;
        end
      end
      S_PAY: begin
        cmd.sel = SEL_PAY;
        if (slot_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  a_load_has_room: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> (!out_valid || !out_stall))
    else $error("output register overwritten while its transfer is stalled");

  a_count_after_div: assert property (@(posedge clk) disable iff (rst)
    (cmd.load_out && cmd.sel == SEL_CNT) |-> !sts.div_busy)
    else $error("packet count taken before the divider finished");

  a_accept_in_idle: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |-> (state == S_IDLE))
    else $error("input transfer accepted outside the idle state");

  a_load_shows: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |=> out_valid)
    else $error("loaded byte not presented on the output");

endmodule

@@ hw/rtl/avctp_tx_fragmenter.sv @@
// ----------------------------------------------------------------------------
// AVCTP transmit fragmenter
// Turns an outgoing message, one payload byte per transfer, into framed
// single, start, continue and end packets for a peer of a given MTU.
// ----------------------------------------------------------------------------
// Each input transfer carries one payload byte; the first byte of a message
// also carries its length, label, command/response bit and profile id, which
// are ignored on later bytes. Each input transfer yields one to five output
// transfers: the header bytes of a packet that this byte opens, then the
// byte itself, flagged with end_of_packet and end_of_message. Bytes inside a
// packet pass at one per cycle while the output is not stalled, straight
// into the output register. A byte that opens a continue or end packet goes
// through acceptance, header byte and payload byte; the first byte of a
// single-packet message through acceptance, three header bytes and payload
// byte. The first byte of a fragmented message adds the count byte, which
// waits for the packet count divider (one quotient bit per cycle); the label
// byte is sent while it runs. A new input transfer is taken in the same
// cycle in which the previous byte leaves the output register; while that
// byte is stalled, the input is stalled too.
// The peer_mtu register is written through cfg_data, is always ready, reads
// values below 48 as 48 and should be written only while no byte is in
// flight. Sizes of continue and end packets use the MTU current when their
// header is produced.
// ----------------------------------------------------------------------------
module avctp_tx_fragmenter
  import avctp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_item_t    in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output out_item_t   out_data
);

  ctl_cmd_t cmd;
  dp_sts_t  sts;

  // The register write completes in the cycle it is offered.
  assign cfg_ready = 1'b1;

  avctp_seq u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  avctp_dpath u_dpath (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_data  (out_data)
  );

endmodule

@@ dv/tb.sv @@
// ----------------------------------------------------------------------------
// AVCTP transmit fragmenter testbench
// Self-checking bench. It streams messages into the fragmenter, predicts the
// framed byte stream from its own copy of the fragmenter state, and compares
// every output transfer field by field, under random idling on both sides.
// ----------------------------------------------------------------------------
module tb
  import avctp_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  // Cycles allowed after the last expected byte before the block counts as quiet.
  localparam int unsigned DRAIN_CYCLES = 32;

  // Hard stop for a hung run, far above the slowest correct run.
  localparam int unsigned CYCLE_LIMIT = 200_000;

  // Length of the receiver hold-off in the back-pressure test.
  localparam int unsigned LONG_HOLD = 400;

  // Items sent by the random phases.
  localparam int unsigned RANDOM_ITEMS = 40;

  localparam int unsigned ITEM_W = $bits(in_item_t);

  // How the receiver side stalls the output channel.
  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_RANDOM,
    STALL_PATTERN
  } stall_mode_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [15:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  in_item_t    in_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_item_t   out_data;

  // Expected output bytes, oldest first.
  out_item_t   expected_bytes[$];

  // Fragmenter state as the bench sees it.
  logic [15:0] peer_mtu_copy = MTU_RESET;
  int unsigned msg_bytes_due = 0;
  int unsigned pkt_bytes_due = 0;
  logic [3:0]  held_label = '0;
  logic        held_cr = 1'b0;

  // Idling controls shared by the test tasks and the driver processes.
  bit          send_gaps = 1'b0;
  int unsigned burst_left = 0;
  stall_mode_t stall_mode = STALL_NONE;
  logic [15:0] stall_pattern = 16'h0000;
  int unsigned hold_request = 0;
  int unsigned hold_count = 0;

  int unsigned items_sent = 0;
  int unsigned errors = 0;
  int unsigned cycle_count = 0;

  avctp_tx_fragmenter u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always #5 clk = ~clk;

  // Watchdog: a run that never drains ends here as a failure.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  function automatic void expect_byte(input logic [7:0] b, input logic eop,
                                      input logic eom, input logic ovf);
    out_item_t e;
    e.out_byte       = b;
    e.end_of_packet  = eop;
    e.end_of_message = eom;
    e.count_overflow = ovf;
    expected_bytes.push_back(e);
  endfunction

  // First header byte: label, packet type, command/response bit, ipid clear.
  function automatic logic [7:0] header_byte(input hdr_type_t t);
    return {held_label, t, held_cr, 1'b0};
  endfunction

  // Works out the framed bytes that one accepted payload byte causes and
  // advances the state copy to match.
  function automatic void frame_payload_byte(input in_item_t item);
    int unsigned mtu;
    int unsigned len;
    int unsigned rest;
    int unsigned pkt_count;
    hdr_type_t   t;
    // Values of the register below the floor act as the floor.
    mtu = (peer_mtu_copy < MTU_FLOOR) ? MTU_FLOOR : peer_mtu_copy;
    if (msg_bytes_due == 0) begin
      // First byte of a message: it opens either a single or a start packet.
      len = (item.msg_length == 0) ? 1 : item.msg_length;
      held_label    = item.msg_label;
      held_cr       = item.cmd_resp;
      msg_bytes_due = len;
      if (len <= mtu - 3) begin
        pkt_bytes_due = len;
        expect_byte(header_byte(TYPE_SINGLE), 1'b0, 1'b0, 1'b0);
      end else begin
        // The start packet carries mtu-4 bytes, the rest go in packets of
        // up to mtu-1 bytes each.
        rest      = len - (mtu - 4);
        pkt_count = rest / (mtu - 1) + 1;
        if (rest % (mtu - 1) != 0) pkt_count++;
        pkt_bytes_due = mtu - 4;
        expect_byte(header_byte(TYPE_START), 1'b0, 1'b0, 1'b0);
        expect_byte(8'(pkt_count), 1'b0, 1'b0, pkt_count > CNT_MAX);
      end
      expect_byte(item.profile_id[15:8], 1'b0, 1'b0, 1'b0);
      expect_byte(item.profile_id[7:0], 1'b0, 1'b0, 1'b0);
    end else if (pkt_bytes_due == 0) begin
      // The previous packet is full, so this byte opens the next fragment,
      // sized with the register value of this moment.
      if (msg_bytes_due > mtu - 1) begin
        t             = TYPE_CONTINUE;
        pkt_bytes_due = mtu - 1;
      end else begin
        t             = TYPE_END;
        pkt_bytes_due = msg_bytes_due;
      end
      expect_byte(header_byte(t), 1'b0, 1'b0, 1'b0);
    end
    msg_bytes_due--;
    pkt_bytes_due--;
    expect_byte(item.payload_byte, pkt_bytes_due == 0, msg_bytes_due == 0, 1'b0);
    if (msg_bytes_due == 0) pkt_bytes_due = 0;
  endfunction

  // ---------------------------------------------------------------------------
  // Output side: receiver stalls and the byte checker
  // ---------------------------------------------------------------------------

  // The receiver stalls either at random, on a rotating bit pattern, or not at
  // all. A long hold-off asked for by a test overrides the mode while it runs.
  always @(posedge clk) begin
    if (hold_request != 0) begin
      hold_count   = hold_request;
      hold_request = 0;
    end
    if (hold_count != 0) begin
      hold_count--;
      out_stall <= 1'b1;
    end else begin
      case (stall_mode)
        STALL_RANDOM: begin
          out_stall <= ($urandom_range(0, 3) == 0);
        end
        STALL_PATTERN: begin
          out_stall     <= stall_pattern[0];
          stall_pattern <= {stall_pattern[0], stall_pattern[15:1]};
        end
        default: begin
          out_stall <= 1'b0;
        end
      endcase
    end
  end

  task automatic report_field(input string name, input logic [7:0] want,
                              input logic [7:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      errors++;
    end
  endtask

  // Each output transfer is compared with the oldest expected byte.
  always @(posedge clk) begin : check_output
    out_item_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_bytes.size() == 0) begin
        $display("%0t: unexpected output, expected none, actual %p", $time, out_data);
        errors++;
      end else begin
        want = expected_bytes.pop_front();
        report_field("out_byte", want.out_byte, out_data.out_byte);
        report_field("end_of_packet", 8'(want.end_of_packet),
                     8'(out_data.end_of_packet));
        report_field("end_of_message", 8'(want.end_of_message),
                     8'(out_data.end_of_message));
        report_field("count_overflow", 8'(want.count_overflow),
                     8'(out_data.count_overflow));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Input side
  // ---------------------------------------------------------------------------

  // Offers one item and returns at the edge where it is taken. Valid is left
  // high between back-to-back items, so they follow without a gap; gaps between
  // bursts lower it first.
  task automatic send_byte(input in_item_t item);
    int unsigned gap;
    if (send_gaps) begin
      if (burst_left == 0) begin
        gap = $urandom_range(1, 6);
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
        burst_left = $urandom_range(1, 24);
      end
      burst_left--;
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (in_stall);
    frame_payload_byte(item);
    items_sent++;
  endtask

  // Opens a message with a random payload byte.
  task automatic send_first(input logic [15:0] len, input logic [3:0] label,
                            input logic cr, input logic [15:0] pid);
    in_item_t item;
    item.payload_byte = 8'($urandom);
    item.msg_length   = len;
    item.msg_label    = label;
    item.cmd_resp     = cr;
    item.profile_id   = pid;
    send_byte(item);
  endtask

  // Sends further message bytes. The header fields are don't-care here, so
  // they get random values to show that they are ignored.
  task automatic send_body(input int unsigned count);
    in_item_t item;
    repeat (count) begin
      item = in_item_t'(ITEM_W'({$urandom, $urandom}));
      send_byte(item);
    end
  endtask

  task automatic send_message(input logic [15:0] len, input logic [3:0] label,
                              input logic cr, input logic [15:0] pid);
    send_first(len, label, cr, pid);
    send_body(((len == 0) ? 1 : len) - 1);
  endtask

  // Stops offering, waits for every expected byte and then lets the block
  // settle before the next register write or the end of the run.
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (expected_bytes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_mtu(input logic [15:0] value);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    peer_mtu_copy = value;
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_idling(input bit gaps, input stall_mode_t mode);
    send_gaps     = gaps;
    burst_left    = 0;
    stall_mode    = mode;
    stall_pattern = 16'($urandom);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Short single-packet messages with the register at its reset value: a zero
  // length taken as one byte, and the extremes of payload, label, command or
  // response bit and profile id.
  task automatic test_reset_mtu();
    in_item_t item;
    set_idling(1'b0, STALL_NONE);
    send_message(16'd0, 4'h3, 1'b0, 16'h0000);
    item = '{payload_byte: 8'h00, msg_length: 16'd2, msg_label: 4'hF,
             cmd_resp: 1'b1, profile_id: 16'hFFFF};
    send_byte(item);
    item.payload_byte = 8'hFF;
    send_byte(item);
    send_message(16'd3, 4'h0, 1'b1, 16'h110E);
  endtask

  // A register value of zero acts as the floor of 48: 45 bytes is the longest
  // message that still fits a single packet.
  task automatic test_single_limit();
    write_mtu(16'd0);
    set_idling(1'b1, STALL_RANDOM);
    send_message(16'd45, 4'h5, 1'b0, 16'hA5A5);
  endtask

  // The register changes at a packet boundary in the middle of a message.
  // After the start packet the rest is sized with the new value: a continue
  // packet of 49 bytes and a one-byte end packet.
  task automatic test_mtu_change_mid_message();
    write_mtu(16'd48);
    set_idling(1'b1, STALL_PATTERN);
    send_first(16'd94, 4'h7, 1'b0, 16'h0017);
    send_body(43);
    write_mtu(16'd50);
    set_idling(1'b0, STALL_RANDOM);
    send_body(50);
  endtask

  // The largest register value: every short message stays a single packet.
  task automatic test_max_mtu();
    write_mtu(16'hFFFF);
    set_idling(1'b1, STALL_RANDOM);
    send_message(16'd5, 4'h9, 1'b1, 16'h8000);
    send_message(16'd1, 4'h6, 1'b0, 16'h00FF);
  endtask

  // The longest message at the smallest MTU: its packet count is far above
  // 255, so the count byte carries only the low eight bits and the overflow
  // flag is set on it. Only the opening bytes are sent, so the run ends with
  // the message still open.
  task automatic test_count_overflow();
    write_mtu(16'd47);
    set_idling(1'b1, STALL_RANDOM);
    send_first(16'hFFFF, 4'hC, 1'b1, 16'h1234);
    send_body(3);
  endtask

  // The receiver holds off for a long stretch while the sender keeps going,
  // so the block fills up and has to stall its input.
  task automatic test_back_pressure();
    write_mtu(16'd48);
    set_idling(1'b0, STALL_NONE);
    hold_request = LONG_HOLD;
    send_message(16'd12, 4'h2, 1'b0, 16'hBEEF);
    send_message(16'd4, 4'hD, 1'b1, 16'h0001);
  endtask

  // Random phases: each picks a register value and an idling style, then
  // sends a few messages of random length and content.
  task automatic test_random_messages();
    int unsigned start;
    int unsigned len;
    start = items_sent;
    while (items_sent - start < RANDOM_ITEMS) begin
      case ($urandom_range(0, 5))
        0:       write_mtu(16'($urandom_range(0, 47)));
        1, 2:    write_mtu(16'($urandom_range(48, 70)));
        3:       write_mtu(16'($urandom_range(71, 300)));
        4:       write_mtu(MTU_RESET);
        default: write_mtu(16'($urandom_range(16'hFF00, 16'hFFFF)));
      endcase
      set_idling(1'($urandom_range(0, 1)), stall_mode_t'($urandom_range(0, 2)));
      repeat ($urandom_range(1, 4)) begin
        if (items_sent - start < RANDOM_ITEMS) begin
          len = ($urandom_range(0, 11) == 0) ? 0 : $urandom_range(1, 64);
          send_message(16'(len), 4'($urandom), 1'($urandom), 16'($urandom));
        end
      end
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_mtu();
    test_single_limit();
    test_mtu_change_mid_message();
    test_max_mtu();
    test_back_pressure();
    test_random_messages();
    test_count_overflow();

    wait_drained();
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
